[rtl/core/acdh_pkg.sv]
package acdh_pkg;

	// Axis count and field widths.
	localparam int AXES    = 3;
	localparam int RAW_W   = 16;
	localparam int SCALE_W = 12;
	localparam int ACC_W   = 14;
	localparam int OFS_W   = 13;
	localparam int SUM_W   = 24;
	localparam int CNT_W   = 10;
	localparam int REST_W  = 12;
	localparam int DB_W    = 8;

	// Stream and register port widths.
	localparam int TDATA_IN_W  = 48;
	localparam int TDATA_OUT_W = 48;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	// Scale factor: counts to cm/s^2 in 16 fractional bits.
	localparam logic [11:0] SCALE_K = 12'd3920;

	// Sample kinds carried in tuser.
	localparam logic MODE_CAL  = 1'b0;
	localparam logic MODE_MEAS = 1'b1;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_REST_X   = 2'd0;
	localparam logic [1:0] REG_REST_Y   = 2'd1;
	localparam logic [1:0] REG_REST_Z   = 2'd2;
	localparam logic [1:0] REG_DEADBAND = 2'd3;

	// Register reset values.
	localparam logic signed [REST_W-1:0] REST_XY_RST = 12'sd0;
	localparam logic signed [REST_W-1:0] REST_Z_RST  = 12'sd980;
	localparam logic [DB_W-1:0]          DEADBAND_RST = 8'd20;

	// Saturation limits.
	localparam logic signed [OFS_W-1:0] OFS_MIN = 13'sh1000;
	localparam logic signed [OFS_W-1:0] OFS_MAX = 13'sh0fff;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 14'sh2000;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 14'sh1fff;

	// Pipeline control shared by all lanes.
	typedef struct packed {
		logic take;        // input request accepted this cycle
		logic move_s2;     // stage 1 moves into stage 2
		logic move_out;    // stage 2 moves into the output register
		logic mode_s1;
		logic mode_s2;
		logic cal_end_s1;  // stage 1 sample closes a calibration run
	} lane_ctl_t;

endpackage

[rtl/core/accel_calibrate_deadband_hysteresis.sv]
// Three-axis accelerometer conditioning: scaling to cm/s^2, offset
// calibration, a deadband around rest and change hysteresis.
// Requests enter on the s_axis channel. tuser carries the mode (0 is a
// calibration sample, 1 a measurement sample) and tdata the raw x, y and z
// readings. Every request yields exactly one result on m_axis: the held
// x, y and z values in tdata and the calibrated flag in tuser.
// The rest values and the deadband sit in four APB registers at byte
// addresses 0, 4, 8 and 12; write them only while the block is idle.
// An accepted request moves through stage 1 and stage 2 to the output
// register. One request per cycle is taken while the pipeline has room.
// The sample that closes a calibration run starts the per-axis mean unit
// (reciprocal multiply, correction multiply, subtract); input is held off
// until the new offsets are written.
// Reset clears the sums, sample count, offsets, held values and the
// calibrated flag, and loads the register defaults.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps accepting until its two stages are full.
module accel_calibrate_deadband_hysteresis import acdh_pkg::*; #(
	parameter int CAL_SAMPLES = 100
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// APB configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	// Input stream.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // raw_x, raw_y, raw_z
	input  logic                   s_axis_tuser,  // mode
	// Output stream.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // accel_x, accel_y, accel_z, zero pad
	output logic                   m_axis_tuser   // calibrated
);

	logic signed [REST_W-1:0] rest_q [AXES];
	logic [DB_W-1:0]          deadband_q;
	logic [CNT_W-1:0]         sample_count_q;
	logic                     busy_q;
	logic                     cal_done_q;

	logic                     v_s1, mode_s1, cal_end_s1;
	logic                     v_s2, mode_s2;
	logic                     out_v_q;
	logic [TDATA_OUT_W-1:0]   tdata_q;
	logic                     tuser_q;

	logic                     cfg_wr;
	logic                     out_free, adv2, adv1;
	logic                     take, move_s2, move_out;
	logic [CNT_W:0]           count_inc;
	logic                     cal_end;
	lane_ctl_t                ctl;
	logic signed [ACC_W-1:0]  accel [AXES];
	logic [AXES-1:0]          lane_done;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q[0]  <= REST_XY_RST;
			rest_q[1]  <= REST_XY_RST;
			rest_q[2]  <= REST_Z_RST;
			deadband_q <= DEADBAND_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_REST_X:   rest_q[0]  <= pwdata[REST_W-1:0];
				REG_REST_Y:   rest_q[1]  <= pwdata[REST_W-1:0];
				REG_REST_Z:   rest_q[2]  <= pwdata[REST_W-1:0];
				REG_DEADBAND: deadband_q <= pwdata[DB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_REST_X:   prdata = DATA_W'(rest_q[0]);
			REG_REST_Y:   prdata = DATA_W'(rest_q[1]);
			REG_REST_Z:   prdata = DATA_W'(rest_q[2]);
			REG_DEADBAND: prdata = DATA_W'(deadband_q);
			default:      prdata = '0;
		endcase
	end

	// Each stage advances whenever the stage after it is empty or moving.
	assign out_free = !out_v_q || m_axis_tready;
	assign move_out = v_s2 && out_free;
	assign adv2     = !v_s2 || out_free;
	assign move_s2  = v_s1 && adv2;
	assign adv1     = !v_s1 || adv2;
	assign s_axis_tready = adv1 && !busy_q;
	assign take     = s_axis_tvalid && s_axis_tready;

	// The sample count runs at acceptance so the closing sample is known
	// before it enters the pipeline.
	assign count_inc = (CNT_W+1)'(sample_count_q) + (CNT_W+1)'(1);
	assign cal_end   = count_inc >= (CNT_W+1)'(CAL_SAMPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			busy_q         <= 1'b0;
			cal_done_q     <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			out_v_q        <= 1'b0;
		end else begin
			if (take && (s_axis_tuser == MODE_CAL)) begin
				sample_count_q <= cal_end ? '0 : count_inc[CNT_W-1:0];
			end
			if (take && (s_axis_tuser == MODE_CAL) && cal_end) begin
				busy_q <= 1'b1;
			end else if (&lane_done) begin
				busy_q <= 1'b0;
			end
			if (move_s2 && (mode_s1 == MODE_CAL) && cal_end_s1) begin
				cal_done_q <= 1'b1;
			end
			if (take) begin
				v_s1 <= 1'b1;
			end else if (move_s2) begin
				v_s1 <= 1'b0;
			end
			if (move_s2) begin
				v_s2 <= 1'b1;
			end else if (move_out) begin
				v_s2 <= 1'b0;
			end
			if (move_out) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1    <= s_axis_tuser;
			cal_end_s1 <= cal_end;
		end
		if (move_s2) begin
			mode_s2 <= mode_s1;
		end
	end

	assign ctl.take       = take;
	assign ctl.move_s2    = move_s2;
	assign ctl.move_out   = move_out;
	assign ctl.mode_s1    = mode_s1;
	assign ctl.mode_s2    = mode_s2;
	assign ctl.cal_end_s1 = cal_end_s1;

	// One lane per axis; each holds its own sum, offset and held value.
	for (genvar i = 0; i < AXES; i++) begin : g_lane
		acdh_lane #(
			.CAL_SAMPLES(CAL_SAMPLES)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.raw     (s_axis_tdata[RAW_W*i +: RAW_W]),
			.rest    (rest_q[i]),
			.deadband(deadband_q),
			.accel   (accel[i]),
			.done    (lane_done[i])
		);
	end

	// Merge the three lanes into one result; the flag is read as it stands
	// after this sample.
	always_ff @(posedge clk) begin
		if (move_out) begin
			tdata_q <= {(TDATA_OUT_W - AXES*ACC_W)'(0), accel[2], accel[1], accel[0]};
			tuser_q <= cal_done_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;

	// No measurement sample may sit in stage 1 while offsets are computed.
	a_no_meas_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !(v_s1 && (mode_s1 == MODE_MEAS)))
		else $error("measurement sample in flight during offset update");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W+1)'(sample_count_q) < (CNT_W+1)'(CAL_SAMPLES))
		else $error("sample count reached run length");

	a_done_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(|lane_done) |-> (busy_q && (&lane_done)))
		else $error("mean unit finished outside a run end");

	a_cal_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cal_done_q |=> cal_done_q)
		else $error("calibrated flag dropped");

endmodule

[rtl/core/acdh_mean.sv]
module acdh_mean import acdh_pkg::*; #(
	parameter int CAL_SAMPLES = 100
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SUM_W-1:0]  sum,
	input  logic signed [REST_W-1:0] rest,
	output logic signed [OFS_W-1:0]  offset,
	output logic                     done
);

	// The magnitude plus half of the count stays below 2^22.
	localparam int MAG_W   = 22;
	localparam int SHIFT   = 22;
	localparam int RECIP_W = 23;
	localparam int PROD_W  = MAG_W + RECIP_W;
	localparam int PN_W    = MAG_W + CNT_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / CAL_SAMPLES);
	localparam logic [MAG_W-1:0]   HALF  = MAG_W'(CAL_SAMPLES / 2);
	localparam logic [CNT_W-1:0]   NVAL  = CNT_W'(CAL_SAMPLES);

	logic [3:0]              vld_q;
	logic                    neg_d1, neg_d2, neg_d3;
	logic [MAG_W-1:0]        mag_d1, mag_d2, mag_d3;
	logic [MAG_W-1:0]        qe_d2, qe_d3;
	logic [PN_W-1:0]         pn_d3;
	logic signed [MAG_W:0]   mean_d4;

	logic [SUM_W-1:0]        abs_sum;
	logic [PROD_W-1:0]       prod;
	logic [PN_W-1:0]         rem;
	logic [MAG_W-1:0]        q_fix;
	logic signed [SUM_W-1:0] diff;

	assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	assign prod    = PROD_W'(mag_d1) * PROD_W'(RECIP);
	assign rem     = PN_W'(mag_d3) - pn_d3;
	// The reciprocal estimate is low by at most one.
	assign q_fix   = qe_d3 + MAG_W'(rem >= PN_W'(NVAL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		neg_d1  <= sum[SUM_W-1];
		mag_d1  <= abs_sum[MAG_W-1:0] + HALF;
		neg_d2  <= neg_d1;
		mag_d2  <= mag_d1;
		qe_d2   <= prod[SHIFT +: MAG_W];
		neg_d3  <= neg_d2;
		mag_d3  <= mag_d2;
		qe_d3   <= qe_d2;
		pn_d3   <= PN_W'(qe_d2) * PN_W'(NVAL);
		mean_d4 <= neg_d3 ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
	end

	assign diff = SUM_W'(rest) - SUM_W'(mean_d4);

	always_comb begin
		if (diff < SUM_W'(OFS_MIN)) begin
			offset = OFS_MIN;
		end else if (diff > SUM_W'(OFS_MAX)) begin
			offset = OFS_MAX;
		end else begin
			offset = diff[OFS_W-1:0];
		end
	end

	assign done = vld_q[3];

endmodule

[rtl/core/acdh_lane.sv]
module acdh_lane import acdh_pkg::*; #(
	parameter int CAL_SAMPLES = 100
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lane_ctl_t                ctl,
	input  logic signed [RAW_W-1:0]  raw,
	input  logic signed [REST_W-1:0] rest,
	input  logic [DB_W-1:0]          deadband,
	output logic signed [ACC_W-1:0]  accel,
	output logic                     done
);

	logic signed [SCALE_W-1:0] scaled_s1;
	logic signed [ACC_W-1:0]   meas_s2;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [OFS_W-1:0]   offset_q;
	logic signed [ACC_W-1:0]   held_q;

	logic                      raw_neg;
	logic [RAW_W:0]            raw_mag;
	logic [28:0]               raw_prod;
	logic [10:0]               raw_q;
	logic signed [SCALE_W-1:0] scaled;
	logic signed [SUM_W-1:0]   sum_next;
	logic                      run_end;
	logic signed [ACC_W:0]     meas_sum;
	logic signed [ACC_W-1:0]   meas;
	logic signed [15:0]        vv, rr, hh, dd;
	logic                      in_band, moved;
	logic signed [ACC_W-1:0]   held_new;
	logic signed [OFS_W-1:0]   mean_ofs;

	// Scale by magnitude so the result truncates toward zero.
	assign raw_neg  = raw[RAW_W-1];
	assign raw_mag  = raw_neg ? (RAW_W+1)'(-$signed({raw[RAW_W-1], raw}))
	                          : {1'b0, raw};
	assign raw_prod = 29'(raw_mag) * 29'(SCALE_K);
	assign raw_q    = raw_prod[26:16];
	assign scaled   = raw_neg ? -$signed({1'b0, raw_q}) : $signed({1'b0, raw_q});

	assign sum_next = sum_q + SUM_W'(scaled_s1);
	assign run_end  = ctl.move_s2 && (ctl.mode_s1 == MODE_CAL) && ctl.cal_end_s1;

	assign meas_sum = (ACC_W+1)'(scaled_s1) + (ACC_W+1)'(offset_q);

	always_comb begin
		if (meas_sum < (ACC_W+1)'(ACC_MIN)) begin
			meas = ACC_MIN;
		end else if (meas_sum > (ACC_W+1)'(ACC_MAX)) begin
			meas = ACC_MAX;
		end else begin
			meas = meas_sum[ACC_W-1:0];
		end
	end

	// Deadband around rest, then change hysteresis around the held value.
	assign vv      = 16'(meas_s2);
	assign rr      = 16'(rest);
	assign hh      = 16'(held_q);
	assign dd      = $signed({8'd0, deadband});
	assign in_band = (vv < rr + dd) && (vv > rr - dd);
	assign moved   = (vv < hh - dd) || (vv > hh + dd);

	always_comb begin
		if (in_band) begin
			held_new = ACC_W'(rest);
		end else if (moved) begin
			held_new = meas_s2;
		end else begin
			held_new = held_q;
		end
	end

	assign accel = (ctl.mode_s2 == MODE_MEAS) ? held_new : held_q;

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			scaled_s1 <= scaled;
		end
		if (ctl.move_s2) begin
			meas_s2 <= meas;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			offset_q <= '0;
			held_q   <= '0;
		end else begin
			if (run_end) begin
				sum_q <= '0;
			end else if (ctl.move_s2 && (ctl.mode_s1 == MODE_CAL)) begin
				sum_q <= sum_next;
			end
			if (done) begin
				offset_q <= mean_ofs;
			end
			if (ctl.move_out && (ctl.mode_s2 == MODE_MEAS)) begin
				held_q <= held_new;
			end
		end
	end

	acdh_mean #(
		.CAL_SAMPLES(CAL_SAMPLES)
	) u_mean (
		.clk   (clk),
		.arst_n(arst_n),
		.start (run_end),
		.sum   (sum_next),
		.rest  (rest),
		.offset(mean_ofs),
		.done  (done)
	);

endmodule

[tb/tb.sv]
module tb import acdh_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Samples per calibration run; the block is built with the same value.
	localparam int CAL_RUN = 100;

	// The run is stopped as failed once this many cycles have passed.
	localparam int CYCLE_LIMIT = 1000000;

	// One request on the input stream: the mode and the three raw readings.
	typedef struct packed {
		logic               mode;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} sample_t;

	// One result: the held value per axis and the calibrated flag.
	typedef struct packed {
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] y;
		logic signed [ACC_W-1:0] z;
		logic                    cal;
	} accel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	logic                   s_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_tdata = '0;   // raw_x, raw_y, raw_z
	logic                   s_tuser = 1'b0; // mode
	logic                   m_axis_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;  // accel_x, accel_y, accel_z, zero pad
	logic                   m_axis_tuser;  // calibrated

	// Requests waiting to be sent, and results the block still owes us,
	// oldest first.
	sample_t pend_q[$];
	accel_t  accel_q[$];

	int mismatches = 0;
	int cycle_count = 0;

	// Our own copy of the block's registers and state.
	logic signed [REST_W-1:0] rest_cfg[3];
	logic [DB_W-1:0]          deadband_cfg;
	logic signed [SUM_W-1:0]  cal_sum[3];
	logic [CNT_W-1:0]         cal_count;
	logic signed [OFS_W-1:0]  axis_ofs[3];
	logic signed [ACC_W-1:0]  held_accel[3];
	logic                     calib_flag;

	// Rough guesses of offsets and held values that the stimulus generator
	// keeps, so that measurement requests land near the deadband edges.
	int g_ofs[3];
	int g_held[3];

	// Runs without any idling on the sending (0) and receiving (1) side.
	int quiet[2] = '{0, 0};

	always #1 clk = ~clk;

	accel_calibrate_deadband_hysteresis #(
		.CAL_SAMPLES(CAL_RUN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_tdata),
		.s_axis_tuser(s_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	function automatic int clamp(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Raw counts to cm/s^2: the magnitude is scaled and shifted, then the
	// sign is put back, so the result truncates toward zero.
	function automatic int to_cms(logic signed [15:0] raw);
		int r;
		int m;
		int q;
		r = raw;
		m = r < 0 ? -r : r;
		q = (m * 3920) >>> 16;
		return r < 0 ? -q : q;
	endfunction

	// Smallest raw magnitude that scales to exactly the wanted cm/s^2.
	function automatic logic signed [15:0] to_raw(int cms);
		int c;
		int m;
		c = clamp(cms, -1960, 1960);
		m = ((c < 0 ? -c : c) * 65536 + 3919) / 3920;
		return 16'(c < 0 ? -m : clamp(m, 0, 32767));
	endfunction

	// Mean of a calibration sum, rounded half away from zero.
	function automatic int round_mean(int s);
		int n;
		n = CAL_RUN;
		if (s >= 0)
			return (s + n / 2) / n;
		return -((-s + n / 2) / n);
	endfunction

	// Advances our copy of the block by one accepted request and returns the
	// result that the block must produce for it.
	function automatic accel_t predict_accel(sample_t s);
		int a[3];
		int v;
		int rest;
		int held;
		int d;
		accel_t res;
		a[0] = to_cms(s.x);
		a[1] = to_cms(s.y);
		a[2] = to_cms(s.z);
		d = int'(deadband_cfg);
		if (s.mode == MODE_CAL) begin
			for (int i = 0; i < 3; i++)
				cal_sum[i] = cal_sum[i] + SUM_W'(a[i]);
			cal_count = cal_count + 1'b1;
			// The sample that fills the run sets the offsets and restarts the sums.
			if (cal_count >= CAL_RUN) begin
				for (int i = 0; i < 3; i++) begin
					axis_ofs[i] = OFS_W'(clamp(int'(rest_cfg[i]) -
						round_mean(int'(cal_sum[i])), -4096, 4095));
					cal_sum[i] = '0;
				end
				cal_count = '0;
				calib_flag = 1'b1;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				v = clamp(a[i] + int'(axis_ofs[i]), -8192, 8191);
				rest = int'(rest_cfg[i]);
				held = int'(held_accel[i]);
				// Inside the open window around rest the output snaps to rest;
				// elsewhere it only follows changes larger than the deadband.
				if (v < rest + d && v > rest - d)
					held_accel[i] = ACC_W'(rest);
				else if (v < held - d || v > held + d)
					held_accel[i] = ACC_W'(v);
			end
		end
		res.x = held_accel[0];
		res.y = held_accel[1];
		res.z = held_accel[2];
		res.cal = calib_flag;
		return res;
	endfunction

	// Idle length for one side: mostly none or short, now and then long, and
	// sometimes a long run of requests with no idling at all.
	function automatic int pick_gap(int side);
		int r;
		if (quiet[side] > 0) begin
			quiet[side]--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet[side] = $urandom_range(30, 80);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int spread(int d);
		int u;
		u = $urandom_range(0, 2 * d + 4);
		return u - (d + 2);
	endfunction

	task automatic push_sample(logic mode, logic signed [15:0] x, logic signed [15:0] y,
		logic signed [15:0] z);
		sample_t s;
		s.mode = mode;
		s.x = x;
		s.y = y;
		s.z = z;
		pend_q.push_back(s);
	endtask

	// A measurement request whose axes aim near rest, near the held value,
	// or anywhere at all.
	task automatic gen_meas();
		logic signed [15:0] r[3];
		int k;
		int v;
		int d;
		int rest;
		d = int'(deadband_cfg);
		for (int i = 0; i < 3; i++) begin
			k = $urandom_range(0, 9);
			rest = int'(rest_cfg[i]);
			if (k < 8) begin
				v = (k < 4 ? rest : g_held[i]) + spread(d);
				r[i] = to_raw(v - g_ofs[i]);
				if (v < rest + d && v > rest - d)
					g_held[i] = rest;
				else if (v < g_held[i] - d || v > g_held[i] + d)
					g_held[i] = v;
			end else begin
				r[i] = 16'($urandom());
			end
		end
		push_sample(MODE_MEAS, r[0], r[1], r[2]);
	endtask

	// A burst of measurement requests with a few stray calibration samples.
	task automatic gen_meas_burst(int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 3)
				push_sample(MODE_CAL, 16'($urandom()), 16'($urandom()), 16'($urandom()));
			else
				gen_meas();
		end
	endtask

	// A full calibration run around a random level per axis, now and then
	// broken by a measurement request.
	task automatic gen_cal_run();
		int b[3];
		int u;
		for (int i = 0; i < 3; i++) begin
			u = $urandom_range(0, 3920);
			b[i] = u - 1960;
		end
		for (int k = 0; k < CAL_RUN; k++) begin
			if ($urandom_range(0, 99) < 5)
				gen_meas();
			push_sample(MODE_CAL, to_raw(b[0] + spread(38)), to_raw(b[1] + spread(38)),
				to_raw(b[2] + spread(38)));
		end
		for (int i = 0; i < 3; i++)
			g_ofs[i] = clamp(int'(rest_cfg[i]) - b[i], -4096, 4095);
	endtask

	// Register write: a setup phase, then an access phase.
	task automatic write_reg(logic [1:0] idx, int val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_REST_X: rest_cfg[0] = val[REST_W-1:0];
			REG_REST_Y: rest_cfg[1] = val[REST_W-1:0];
			REG_REST_Z: rest_cfg[2] = val[REST_W-1:0];
			REG_DEADBAND: deadband_cfg = val[DB_W-1:0];
			default: ;
		endcase
	endtask

	// Waits until every request has been sent and every result has come,
	// then lets the mean unit and the output stage settle.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pend_q.size() != 0 || s_tvalid || accel_q.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	// Sender: holds a request until it is taken, then either idles for a
	// while or presents the next request from the queue.
	sample_t in_flight;
	int send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_axis_tready)
				accel_q.push_back(predict_accel(in_flight));
			if (!s_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pend_q.size() != 0) begin
					in_flight = pend_q.pop_front();
					s_tdata <= {in_flight.z, in_flight.y, in_flight.x};
					s_tuser <= in_flight.mode;
					s_tvalid <= 1'b1;
					send_gap = pick_gap(0);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: compares every accepted result with the oldest expectation
	// and stalls the output stream at random.
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin : result_check
		accel_t want;
		logic signed [ACC_W-1:0] got_x;
		logic signed [ACC_W-1:0] got_y;
		logic signed [ACC_W-1:0] got_z;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_tready) begin
				got_x = m_axis_tdata[ACC_W-1:0];
				got_y = m_axis_tdata[2*ACC_W-1:ACC_W];
				got_z = m_axis_tdata[3*ACC_W-1:2*ACC_W];
				if (accel_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with no request pending: x=%0d y=%0d z=%0d cal=%0b",
							got_x, got_y, got_z, m_axis_tuser);
				end else begin
					want = accel_q.pop_front();
					if (got_x !== want.x || got_y !== want.y || got_z !== want.z ||
						m_axis_tuser !== want.cal) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at cycle %0d: ", cycle_count,
								"expected x=%0d y=%0d z=%0d cal=%0b, ",
								want.x, want.y, want.z, want.cal,
								"got x=%0d y=%0d z=%0d cal=%0b",
								got_x, got_y, got_z, m_axis_tuser);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 99) < 25)
					stall_left = pick_gap(1);
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** accel_calibrate_deadband_hysteresis: FAILED **");
			$finish;
		end
	end

	initial begin
		int rx;
		int ry;
		int rz;
		int db;
		int u;

		rest_cfg[0] = REST_XY_RST;
		rest_cfg[1] = REST_XY_RST;
		rest_cfg[2] = REST_Z_RST;
		deadband_cfg = DEADBAND_RST;
		calib_flag = 1'b0;
		cal_count = '0;
		for (int i = 0; i < 3; i++) begin
			cal_sum[i] = '0;
			axis_ofs[i] = '0;
			held_accel[i] = '0;
			g_ofs[i] = 0;
			g_held[i] = 0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset register values. The first ones are
		// measurements before any calibration, so the offsets are still zero;
		// they cover the raw extremes and both sides of each deadband edge.
		push_sample(MODE_MEAS, 16'sd0, 16'sd0, 16'sd0);
		push_sample(MODE_MEAS, 16'sh7fff, 16'sh8000, to_raw(980));
		push_sample(MODE_MEAS, 16'sh8000, 16'sh7fff, -16'sd1);
		push_sample(MODE_MEAS, 16'sd1, -16'sd1, 16'sh7fff);
		push_sample(MODE_MEAS, -16'sd1, 16'sd1, 16'sh8000);
		push_sample(MODE_MEAS, to_raw(19), to_raw(-19), to_raw(999));
		push_sample(MODE_MEAS, to_raw(20), to_raw(-20), to_raw(1000));
		push_sample(MODE_MEAS, to_raw(21), to_raw(-21), to_raw(961));
		push_sample(MODE_MEAS, to_raw(40), to_raw(-40), to_raw(960));
		push_sample(MODE_MEAS, to_raw(41), to_raw(-41), to_raw(959));
		push_sample(MODE_MEAS, to_raw(61), to_raw(-60), to_raw(940));
		push_sample(MODE_MEAS, to_raw(62), to_raw(-82), to_raw(1500));
		// A few calibration samples at the extremes start a run that the
		// first random phase will finish early.
		push_sample(MODE_CAL, 16'sh7fff, 16'sh8000, 16'sd0);
		push_sample(MODE_CAL, 16'sh8000, 16'sh7fff, to_raw(980));
		push_sample(MODE_CAL, 16'sd0, -16'sd1, 16'sd1);
		push_sample(MODE_MEAS, to_raw(5), to_raw(-5), to_raw(985));
		wait_idle();

		// Each phase changes every register while the block is idle, then
		// sends measurements, a calibration run and more measurements, and
		// finally holds off until every result has come back.
		for (int p = 0; p < 11; p++) begin
			if (p == 0) begin
				// Rest at the negative and positive limits, deadband zero:
				// the rest window is empty and any change moves the output.
				rx = -2048;
				ry = 2047;
				rz = 0;
				db = 0;
			end else if (p == 1) begin
				rx = 2047;
				ry = -2048;
				rz = 980;
				db = 255;
			end else if (p == 2) begin
				rx = 0;
				ry = 0;
				rz = 980;
				db = 20;
			end else begin
				u = $urandom_range(0, 4095);
				rx = u - 2048;
				u = $urandom_range(0, 4095);
				ry = u - 2048;
				u = $urandom_range(0, 4095);
				rz = u - 2048;
				db = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 255);
			end
			write_reg(REG_REST_X, rx);
			write_reg(REG_REST_Y, ry);
			write_reg(REG_REST_Z, rz);
			write_reg(REG_DEADBAND, db);
			@(negedge clk);
			for (int i = 0; i < 3; i++) begin
				g_ofs[i] = axis_ofs[i];
				g_held[i] = held_accel[i];
			end
			gen_meas_burst(20);
			gen_cal_run();
			gen_meas_burst(25);
			wait_idle();
		end

		if (mismatches == 0 && accel_q.size() == 0)
			$display("** accel_calibrate_deadband_hysteresis: PASSED **");
		else
			$display("** accel_calibrate_deadband_hysteresis: FAILED **");
		$finish;
	end

endmodule
